// ===== rtl/nht_pkg.sv =====
package nht_pkg;

	localparam int G_BITS = 31;
	localparam logic [30:0] C1_RESET = 31'd65536;
	localparam logic [2:0] VOIGT_LAST = 3'd5;

	// floor division by three or nine: 2^24 - 1 is a multiple of both, so
	// x = xh*(2^24-1) + (xh+xl) and only the 25-bit sum needs a reciprocal
	localparam logic [23:0] DIV3_K = 24'((2**24 - 1) / 3);
	localparam logic [27:0] DIV3_M = 28'((2**29 + 2) / 3);
	localparam logic [23:0] DIV9_K = 24'((2**24 - 1) / 9);
	localparam logic [27:0] DIV9_M = 28'((2**29 + 8) / 9);

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	typedef struct packed {
		logic [30:0]        jacobian_det;
		logic signed [31:0] cg_diag_one;
		logic signed [31:0] cg_diag_two;
		logic signed [31:0] cg_diag_three;
		logic signed [31:0] inv_cg_11;
		logic signed [31:0] inv_cg_22;
		logic signed [31:0] inv_cg_33;
		logic signed [31:0] inv_cg_12;
		logic signed [31:0] inv_cg_13;
		logic signed [31:0] inv_cg_23;
	} nht_item_t;

	typedef struct packed {
		logic [2:0]         row_voigt;
		logic [2:0]         col_voigt;
		logic signed [31:0] stress_value;
		logic signed [31:0] tangent_value;
		logic               last_entry;
	} nht_result_t;

	// clamp to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > SAT_HI) return 32'sh7fffffff;
		if (v < SAT_LO) return 32'sh80000000;
		return v[31:0];
	endfunction

	// first tensor index of a voigt slot
	function automatic logic [1:0] voigt_i(input logic [2:0] v);
		case (v)
			3'd1:    return 2'd1;
			3'd2:    return 2'd2;
			3'd5:    return 2'd1;
			default: return 2'd0;
		endcase
	endfunction

	// second tensor index of a voigt slot
	function automatic logic [1:0] voigt_j(input logic [2:0] v);
		case (v)
			3'd1:    return 2'd1;
			3'd2:    return 2'd2;
			3'd3:    return 2'd1;
			3'd4:    return 2'd2;
			3'd5:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	// voigt slot of a symmetric index pair
	function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
		case ({a, b})
			4'b0000:          return 3'd0;
			4'b0101:          return 3'd1;
			4'b1010:          return 3'd2;
			4'b0001, 4'b0100: return 3'd3;
			4'b0010, 4'b1000: return 3'd4;
			default:          return 3'd5;
		endcase
	endfunction

	// pick one of six packed 32-bit entries
	function automatic logic signed [31:0] sel_ci(input logic [191:0] vec, input logic [2:0] idx);
		case (idx)
			3'd0:    return vec[31:0];
			3'd1:    return vec[63:32];
			3'd2:    return vec[95:64];
			3'd3:    return vec[127:96];
			3'd4:    return vec[159:128];
			default: return vec[191:160];
		endcase
	endfunction

	// unsigned divide of a 48-bit value by three or nine
	function automatic logic [47:0] udiv_small(input logic [47:0] x, input logic [23:0] kq,
			input logic [27:0] m);
		logic [24:0] s;
		logic [52:0] p;
		s = 25'(x[47:24]) + 25'(x[23:0]);
		p = 53'(s) * 53'(m);
		return 48'(x[47:24]) * 48'(kq) + 48'(p[52:29]);
	endfunction

	// floor division of a signed value by three or nine, magnitudes below 2^48
	function automatic logic signed [63:0] fdiv_small(input logic signed [63:0] v,
			input logic [23:0] kq, input logic [27:0] m);
		logic [63:0] u;
		logic [63:0] q;
		u = v[63] ? ~v : v;
		q = 64'(udiv_small(u[47:0], kq, m));
		return v[63] ? ~q : q;
	endfunction

endpackage

// ===== rtl/neo_hookean_stress_tangent.sv =====
// Neo-Hookean stress and tangent unit. Each accepted item (J, diagonal of C and the six
// entries of the symmetric inverse of C, all fixed point with FRAC_BITS fraction bits)
// yields 36 result items in Voigt order, row-major, row and column 11,22,33,12,13,23; each
// carries the stress entry of its row, the tangent entry of its row and column, and
// last_entry on the 36th. The result sequencer issues one tangent entry per cycle, unless the
// output stalls, into a seven-stage pipeline, and that limits the rate of new items. The
// J^(-2/3) search runs 31 bit steps, the MULB and MULA multiply states and the DONE handoff
// state per item and overlaps the previous item's results. shear_modulus_c1 may be written
// only while no item is in flight; a stall on the result side freezes the whole pipeline.
module neo_hookean_stress_tangent #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  nht_pkg::nht_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output nht_pkg::nht_result_t result,
	input  logic                 cfg_we,
	input  logic [30:0]          cfg_wdata
);

	// accumulator width for the cube search, exponent width, bit counter width
	localparam int ACC_W = ((5 * FRAC_BITS > 62) ? 5 * FRAC_BITS : 62) + 5;
	localparam int EXP_W = $clog2(5 * FRAC_BITS + 1) + 2;
	localparam int K_W = $clog2(nht_pkg::G_BITS);

	localparam logic [2:0] FS_IDLE = 3'd0;
	localparam logic [2:0] FS_SRCH = 3'd1;
	localparam logic [2:0] FS_MULB = 3'd2;
	localparam logic [2:0] FS_MULA = 3'd3;
	localparam logic [2:0] FS_DONE = 3'd4;

	// configuration
	logic [30:0] c1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= nht_pkg::C1_RESET;
		end else if (cfg_we) begin
			c1_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// front end: g = floor(J^(-2/3)), b, trace, a0
	// g is built msb first; with g = H*2^(k+1) the trial (2H+1)*2^k passes when
	// (2H+1)^3*D <= 2^(5F-3k), D = J^2; H^3 D, H^2 D and H D are kept exactly
	// ---------------------------------------------------------------
	logic [2:0]             fst_q;
	logic [K_W-1:0]         k_q;
	logic [nht_pkg::G_BITS-1:0] g_q;
	logic [ACC_W-1:0]       a3_q, a2_q, a1_q;
	logic [61:0]            d_q;
	logic signed [31:0]     tr_q;
	logic [191:0]           ci_q;
	logic [61:0]            pb_q;
	logic signed [31:0]     b_q;
	logic signed [63:0]     pa_q;

	logic [30:0]            jd_c;
	logic signed [33:0]     tr_sum;
	logic [ACC_W-1:0]       d_ext, trial, lim;
	logic signed [EXP_W-1:0] exp_c;
	logic                   pass;
	logic [61:0]            pb_sh;
	logic signed [31:0]     b_c;
	logic                   load;

	assign item_ready = (fst_q == FS_IDLE);

	always_comb begin
		jd_c = (item.jacobian_det == '0) ? 31'd1 : item.jacobian_det;
		tr_sum = 34'(item.cg_diag_one) + 34'(item.cg_diag_two) + 34'(item.cg_diag_three);
		d_ext = ACC_W'(d_q);
		trial = (a3_q << 3) + (a2_q << 3) + (a2_q << 2) + (a1_q << 2) + (a1_q << 1) + d_ext;
		exp_c = EXP_W'(5 * FRAC_BITS) - EXP_W'(3 * k_q);
		lim = ACC_W'(1) << exp_c[EXP_W-2:0];
		// a negative exponent means the limit is below one: never passes
		pass = !exp_c[EXP_W-1] && (trial <= lim);
		// b = floor(2*C1*g / 2^F), never negative
		pb_sh = pb_q >> (FRAC_BITS - 1);
		b_c = (pb_sh > 62'h7fffffff) ? 32'sh7fffffff : signed'(pb_sh[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= FS_IDLE;
		end else begin
			unique case (fst_q)
				FS_IDLE: if (item_valid) fst_q <= FS_SRCH;
				FS_SRCH: if (k_q == '0) fst_q <= FS_MULB;
				FS_MULB: fst_q <= FS_MULA;
				FS_MULA: fst_q <= FS_DONE;
				FS_DONE: if (load) fst_q <= FS_IDLE;
				default: fst_q <= FS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fst_q == FS_IDLE && item_valid) begin
			d_q <= 62'(jd_c) * 62'(jd_c);
			a3_q <= '0;
			a2_q <= '0;
			a1_q <= '0;
			g_q <= '0;
			k_q <= K_W'(nht_pkg::G_BITS - 1);
			tr_q <= nht_pkg::sat32(66'(tr_sum));
			ci_q <= {item.inv_cg_23, item.inv_cg_13, item.inv_cg_12,
				item.inv_cg_33, item.inv_cg_22, item.inv_cg_11};
		end
		if (fst_q == FS_SRCH) begin
			k_q <= k_q - K_W'(1);
			if (pass) begin
				a3_q <= trial;
				a2_q <= (a2_q << 2) + (a1_q << 2) + d_ext;
				a1_q <= (a1_q << 1) + d_ext;
				g_q[k_q] <= 1'b1;
			end else begin
				a3_q <= a3_q << 3;
				a2_q <= a2_q << 2;
				a1_q <= a1_q << 1;
			end
		end
		if (fst_q == FS_MULB) begin
			pb_q <= 62'(c1_q) * 62'(g_q);
		end
		if (fst_q == FS_MULA) begin
			b_q <= b_c;
			pa_q <= 64'(b_c) * 64'(tr_q);
		end
	end

	// ---------------------------------------------------------------
	// result sequencer: holds one item's constants, walks row and column
	// ---------------------------------------------------------------
	logic               en;
	logic               act_q;
	logic [2:0]         row_q, col_q;
	logic signed [31:0] hb_q, ha_q;
	logic [191:0]       hci_q;
	logic               issue, issue_last;

	// whole pipeline moves unless the output holds an item that is not taken
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	assign en = !v_s7 || result_ready;
	assign issue = act_q && en;
	assign issue_last = issue && (row_q == nht_pkg::VOIGT_LAST) && (col_q == nht_pkg::VOIGT_LAST);
	assign load = (fst_q == FS_DONE) && (!act_q || issue_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			row_q <= '0;
			col_q <= '0;
		end else if (issue) begin
			if (issue_last) begin
				act_q <= 1'b0;
				row_q <= '0;
				col_q <= '0;
			end else if (col_q == nht_pkg::VOIGT_LAST) begin
				col_q <= '0;
				row_q <= row_q + 3'd1;
			end else begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hb_q <= b_q;
			ha_q <= nht_pkg::sat32(66'(pa_q >>> FRAC_BITS));
			hci_q <= ci_q;
		end
	end

	// ---------------------------------------------------------------
	// result pipeline
	// s1 entry selection, s2 first products, s3 scale and clamp, s4 a0 products,
	// s5 scale, s6 divide by three or nine, s7 sums and clamp (output register)
	// ---------------------------------------------------------------
	logic [1:0] i_c, j_c, k_c, l_c;

	always_comb begin
		i_c = nht_pkg::voigt_i(row_q);
		j_c = nht_pkg::voigt_j(row_q);
		k_c = nht_pkg::voigt_i(col_q);
		l_c = nht_pkg::voigt_j(col_q);
	end

	// per-stage tags
	logic [2:0] row_s1, row_s2, row_s3, row_s4, row_s5, row_s6;
	logic [2:0] col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;
	logic       last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic       dr_s1, dr_s2, dr_s3, dr_s4, dr_s5, dr_s6;
	logic       dc_s1, dc_s2, dc_s3, dc_s4, dc_s5, dc_s6;
	logic signed [31:0] b_s1, b_s2, b_s3, b_s4, b_s5, b_s6;
	logic signed [31:0] a0_s1, a0_s2, a0_s3;

	logic signed [31:0] cij_s1, ckl_s1, cik_s1, cjl_s1, cil_s1, cjk_s1;
	logic signed [63:0] pm_s2, pq1_s2, pq2_s2, pb1_s2, pb2_s2;
	logic signed [64:0] ps_s2;
	logic signed [31:0] m_s3;
	logic signed [32:0] q_s3;
	logic signed [63:0] sh_s3, tb1_s3, tb2_s3, sh_s4, tb1_s4, tb2_s4, sh_s5, tb1_s5, tb2_s5;
	logic signed [63:0] ta_s4;
	logic signed [64:0] tq_s4;
	logic signed [63:0] ta_s5, tq_s5;
	logic signed [63:0] sd_s6, ad_s6, qd_s6, b1d_s6, b2d_s6;
	logic signed [32:0] na_c;
	nht_pkg::nht_result_t out_s7;

	assign na_c = -(33'(a0_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= act_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: pick entries of the inverse for this row and column
			row_s1 <= row_q;
			col_s1 <= col_q;
			last_s1 <= (row_q == nht_pkg::VOIGT_LAST) && (col_q == nht_pkg::VOIGT_LAST);
			dr_s1 <= (i_c == j_c);
			dc_s1 <= (k_c == l_c);
			b_s1 <= hb_q;
			a0_s1 <= ha_q;
			cij_s1 <= nht_pkg::sel_ci(hci_q, row_q);
			ckl_s1 <= nht_pkg::sel_ci(hci_q, col_q);
			cik_s1 <= nht_pkg::sel_ci(hci_q, nht_pkg::pair_idx(i_c, k_c));
			cjl_s1 <= nht_pkg::sel_ci(hci_q, nht_pkg::pair_idx(j_c, l_c));
			cil_s1 <= nht_pkg::sel_ci(hci_q, nht_pkg::pair_idx(i_c, l_c));
			cjk_s1 <= nht_pkg::sel_ci(hci_q, nht_pkg::pair_idx(j_c, k_c));

			// s2: raw products
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			last_s2 <= last_s1;
			dr_s2 <= dr_s1;
			dc_s2 <= dc_s1;
			b_s2 <= b_s1;
			a0_s2 <= a0_s1;
			pm_s2 <= cij_s1 * ckl_s1;
			pq1_s2 <= cik_s1 * cjl_s1;
			pq2_s2 <= cil_s1 * cjk_s1;
			ps_s2 <= na_c * cij_s1;
			pb1_s2 <= b_s1 * ckl_s1;
			pb2_s2 <= b_s1 * cij_s1;

			// s3: drop fraction bits, clamp the inverse products
			row_s3 <= row_s2;
			col_s3 <= col_s2;
			last_s3 <= last_s2;
			dr_s3 <= dr_s2;
			dc_s3 <= dc_s2;
			b_s3 <= b_s2;
			a0_s3 <= a0_s2;
			m_s3 <= nht_pkg::sat32(66'(pm_s2 >>> FRAC_BITS));
			q_s3 <= 33'(nht_pkg::sat32(66'(pq1_s2 >>> FRAC_BITS)))
				+ 33'(nht_pkg::sat32(66'(pq2_s2 >>> FRAC_BITS)));
			sh_s3 <= 64'(ps_s2 >>> FRAC_BITS);
			// factor two folded into the shift
			tb1_s3 <= pb1_s2 >>> (FRAC_BITS - 1);
			tb2_s3 <= pb2_s2 >>> (FRAC_BITS - 1);

			// s4: products with a0
			row_s4 <= row_s3;
			col_s4 <= col_s3;
			last_s4 <= last_s3;
			dr_s4 <= dr_s3;
			dc_s4 <= dc_s3;
			b_s4 <= b_s3;
			sh_s4 <= sh_s3;
			tb1_s4 <= tb1_s3;
			tb2_s4 <= tb2_s3;
			ta_s4 <= a0_s3 * m_s3;
			tq_s4 <= a0_s3 * q_s3;

			// s5: drop fraction bits
			row_s5 <= row_s4;
			col_s5 <= col_s4;
			last_s5 <= last_s4;
			dr_s5 <= dr_s4;
			dc_s5 <= dc_s4;
			b_s5 <= b_s4;
			sh_s5 <= sh_s4;
			tb1_s5 <= tb1_s4;
			tb2_s5 <= tb2_s4;
			ta_s5 <= ta_s4 >>> (FRAC_BITS - 1);
			tq_s5 <= 64'(tq_s4 >>> FRAC_BITS);

			// s6: floor division by three or nine
			row_s6 <= row_s5;
			col_s6 <= col_s5;
			last_s6 <= last_s5;
			dr_s6 <= dr_s5;
			dc_s6 <= dc_s5;
			b_s6 <= b_s5;
			sd_s6 <= nht_pkg::fdiv_small(sh_s5, nht_pkg::DIV3_K, nht_pkg::DIV3_M);
			ad_s6 <= nht_pkg::fdiv_small(ta_s5, nht_pkg::DIV9_K, nht_pkg::DIV9_M);
			qd_s6 <= nht_pkg::fdiv_small(tq_s5, nht_pkg::DIV3_K, nht_pkg::DIV3_M);
			b1d_s6 <= nht_pkg::fdiv_small(tb1_s5, nht_pkg::DIV3_K, nht_pkg::DIV3_M);
			b2d_s6 <= nht_pkg::fdiv_small(tb2_s5, nht_pkg::DIV3_K, nht_pkg::DIV3_M);

			// s7: diagonal terms, one clamp at the end
			out_s7.row_voigt <= row_s6;
			out_s7.col_voigt <= col_s6;
			out_s7.last_entry <= last_s6;
			out_s7.stress_value <= nht_pkg::sat32(66'(sd_s6) + (dr_s6 ? 66'(b_s6) : 66'sd0));
			out_s7.tangent_value <= nht_pkg::sat32(66'(ad_s6) + 66'(qd_s6)
				- (dr_s6 ? 66'(b1d_s6) : 66'sd0) - (dc_s6 ? 66'(b2d_s6) : 66'sd0));
		end
	end

	assign result_valid = v_s7;
	assign result = out_s7;

endmodule

// ===== rtl/nht_checker.sv =====
module nht_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input nht_pkg::nht_result_t result
);

	logic [2:0] exp_row_q, exp_col_q;
	logic       take;

	assign take = result_valid && result_ready;

	// expected voigt position of the next result taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_row_q <= '0;
			exp_col_q <= '0;
		end else if (take) begin
			if (exp_col_q == nht_pkg::VOIGT_LAST) begin
				exp_col_q <= '0;
				exp_row_q <= (exp_row_q == nht_pkg::VOIGT_LAST) ? 3'd0 : exp_row_q + 3'd1;
			end else begin
				exp_col_q <= exp_col_q + 3'd1;
			end
		end
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (result.row_voigt == exp_row_q) && (result.col_voigt == exp_col_q))
		else $error("results out of voigt order");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.last_entry == ((result.row_voigt == nht_pkg::VOIGT_LAST)
			&& (result.col_voigt == nht_pkg::VOIGT_LAST)))
		else $error("last_entry flag wrong");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while search busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

endmodule

bind neo_hookean_stress_tangent nht_checker u_nht_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
